>>> hw/rtl/refcounted_segment_table_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the segment table checker
// Each macro emits one labeled concurrent assertion, clocked on clk and
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef REFCOUNTED_SEGMENT_TABLE_MACROS_SVH
`define REFCOUNTED_SEGMENT_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment table check failed");

// Consequent must hold in the cycle after the antecedent.
`define RCST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment table check failed");

`endif

>>> hw/rtl/rcst_pkg.sv
// ---------------------------------------------------------------------------
// rcst_pkg
// Shared types and constants of the reference-counted segment table.
// ---------------------------------------------------------------------------
`default_nettype none

package rcst_pkg;

  // Table geometry.
  localparam int SLOTS      = 64;
  localparam int ID_BITS    = 16;
  localparam int FRAME_BITS = 20;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed widths of the stream fields.
  localparam int CMD_IN_W    = 1;
  localparam int ID_IN_W     = 16;
  localparam int FRAME_IN_W  = 20;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 6;
  localparam int FRAME_OUT_W = 20;
  localparam int COUNT_W     = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  // Commands.
  localparam logic [CMD_IN_W-1:0] CMD_OPEN  = 1'b0;
  localparam logic [CMD_IN_W-1:0] CMD_CLOSE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OPENED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_ID    = 3'd5;

  // One table slot; an id of zero marks the slot empty.
  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [FRAME_BITS-1:0] frame;
    logic [COUNT_W-1:0]    count;
  } ent_t;

  // Write into the slot whose index matches, while the ring stands still.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    ent_t              ent;
  } wr_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [FRAME_OUT_W-1:0] frame;
    logic [COUNT_W-1:0]     count;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/rcst_cell.sv
// ---------------------------------------------------------------------------
// rcst_cell
// One slot of the segment ring: shifts toward the head or takes a write.
// ---------------------------------------------------------------------------
`default_nettype none

module rcst_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rcst_pkg::SLOT_W-1:0] cell_idx,
  input  logic                       shift,
  input  rcst_pkg::ent_t             nxt,
  input  rcst_pkg::wr_t              wr,
  output rcst_pkg::ent_t             ent
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (shift) begin
      ent <= nxt;
    end else if (wr.en && (wr.idx == cell_idx)) begin
      ent <= wr.ent;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rcst_ctrl.sv
// ---------------------------------------------------------------------------
// rcst_ctrl
// Request sequencer: watches the ring head during a full rotation (none for
// a zero id), then decides the result and the single slot update.
// ---------------------------------------------------------------------------
`default_nettype none

module rcst_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rcst_pkg::CMD_IN_W-1:0]     in_cmd,
  input  logic [rcst_pkg::ID_IN_W-1:0]      in_id,
  input  logic [rcst_pkg::FRAME_IN_W-1:0]   in_frame,
  input  rcst_pkg::ent_t                    head,
  input  logic                              out_free,
  output logic                              shift,
  output rcst_pkg::wr_t                     wr,
  output rcst_pkg::res_t                    res,
  output logic                              res_load
);

  rcst_pkg::state_t state, state_next;

  logic [rcst_pkg::SLOT_W-1:0]     cnt;
  logic [rcst_pkg::CMD_IN_W-1:0]   req_cmd;
  logic [rcst_pkg::ID_BITS-1:0]    req_id;
  logic [rcst_pkg::FRAME_BITS-1:0] req_frame;
  logic                            bad;
  logic                            found;
  logic                            have_empty;
  logic [rcst_pkg::SLOT_W-1:0]     hit_idx;
  logic [rcst_pkg::SLOT_W-1:0]     empty_idx;
  logic [rcst_pkg::FRAME_BITS-1:0] hit_frame;
  logic [rcst_pkg::COUNT_W-1:0]    hit_count;
  logic                            accept;
  logic                            scan_last;

  assign accept    = (state == rcst_pkg::S_IDLE) && in_valid;
  assign scan_last = (cnt == rcst_pkg::SLOT_W'(rcst_pkg::SLOTS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      rcst_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (in_id == '0) ? rcst_pkg::S_DONE : rcst_pkg::S_SCAN;
        end
      end
      rcst_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = rcst_pkg::S_DONE;
        end
      end
      rcst_pkg::S_DONE: begin
        if (out_free) begin
          state_next = rcst_pkg::S_IDLE;
        end
      end
      default: state_next = rcst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and scan bookkeeping. The head shows slot cnt.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      found      <= 1'b0;
      have_empty <= 1'b0;
      bad        <= 1'b0;
    end else if (accept) begin
      cnt        <= '0;
      found      <= 1'b0;
      have_empty <= 1'b0;
      bad        <= (in_id == '0);
    end else if (state == rcst_pkg::S_SCAN) begin
      cnt <= cnt + 1'b1;
      if (!found && !have_empty && (head.id == '0)) begin
        have_empty <= 1'b1;
      end
      if (!found && (head.id == req_id)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd   <= in_cmd;
      req_id    <= rcst_pkg::ID_BITS'(in_id);
      req_frame <= rcst_pkg::FRAME_BITS'(in_frame);
    end
    if (state == rcst_pkg::S_SCAN) begin
      if (!found && !have_empty && (head.id == '0)) begin
        empty_idx <= cnt;
      end
      if (!found && (head.id == req_id)) begin
        hit_idx   <= cnt;
        hit_frame <= head.frame;
        hit_count <= head.count;
      end
    end
  end

  always_comb begin
    logic [rcst_pkg::COUNT_W-1:0] cnt_up;
    logic [rcst_pkg::COUNT_W-1:0] cnt_dn;
    cnt_up   = (hit_count == rcst_pkg::COUNT_MAX) ? hit_count : hit_count + 1'b1;
    cnt_dn   = hit_count - 1'b1;
    in_ready = (state == rcst_pkg::S_IDLE);
    shift    = (state == rcst_pkg::S_SCAN);
    res_load = (state == rcst_pkg::S_DONE) && out_free;
    res      = '0;
    wr       = '0;
    if (bad) begin
      res.status = rcst_pkg::ST_BAD_ID;
    end else if (req_cmd == rcst_pkg::CMD_OPEN) begin
      if (found) begin
        res.status = rcst_pkg::ST_OPENED;
        res.slot   = rcst_pkg::SLOT_OUT_W'(hit_idx);
        res.frame  = rcst_pkg::FRAME_OUT_W'(hit_frame);
        res.count  = cnt_up;
        wr.en      = 1'b1;
        wr.idx     = hit_idx;
        wr.ent     = '{id: req_id, frame: hit_frame, count: cnt_up};
      end else if (have_empty) begin
        res.status = rcst_pkg::ST_CREATED;
        res.slot   = rcst_pkg::SLOT_OUT_W'(empty_idx);
        res.frame  = rcst_pkg::FRAME_OUT_W'(req_frame);
        res.count  = rcst_pkg::COUNT_ONE;
        wr.en      = 1'b1;
        wr.idx     = empty_idx;
        wr.ent     = '{id: req_id, frame: req_frame, count: rcst_pkg::COUNT_ONE};
      end else begin
        res.status = rcst_pkg::ST_FULL;
      end
    end else begin
      if (!found) begin
        res.status = rcst_pkg::ST_NOT_FOUND;
      end else begin
        res.status = rcst_pkg::ST_CLOSED;
        res.slot   = rcst_pkg::SLOT_OUT_W'(hit_idx);
        res.frame  = rcst_pkg::FRAME_OUT_W'(hit_frame);
        wr.en      = 1'b1;
        wr.idx     = hit_idx;
        if (hit_count > rcst_pkg::COUNT_ONE) begin
          res.count = cnt_dn;
          wr.ent    = '{id: req_id, frame: hit_frame, count: cnt_dn};
        end else begin
          // Last reference gone: the slot is freed.
          res.count = '0;
          wr.ent    = '0;
        end
      end
    end
    wr.en = wr.en && res_load;
  end

endmodule

`default_nettype wire

>>> hw/rtl/refcounted_segment_table.sv
// ---------------------------------------------------------------------------
// refcounted_segment_table
// Table of shared segments with reference counts, built as a ring of slot
// cells that rotates past a single compare point at the head.
// ---------------------------------------------------------------------------
//
//   Channel  | Direction | tdata (low bit first)               | tuser
//   ---------+-----------+-------------------------------------+---------------
//   s_axis   | in        | segment_id[15:0], fresh_frame[19:0] | command
//   m_axis   | out       | slot_index, frame_out, ref_count    | status
//
// A request with a nonzero id raises m_axis_tvalid after one full rotation
// of the slot ring past the head compare, then a final step that decides
// and writes back the single affected slot. A request with id zero skips
// the rotation and goes straight to the final step. The next request can
// be taken only once the sequencer has returned to its idle state.
// One request is in flight at a time; s_axis_tready is high whenever the
// sequencer is idle, even while the previous result waits in the output
// register. A stalled result holds the sequencer in its final step until
// the output register frees up. Synchronous reset clears all slots at once.
// ---------------------------------------------------------------------------
`default_nettype none

module refcounted_segment_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields, low bit up: segment_id[15:0], fresh_frame[35:16], zero pad.
  input  logic [rcst_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Fields, low bit up: command.
  input  logic [rcst_pkg::CMD_IN_W-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields, low bit up: slot_index[5:0], frame_out[25:6], ref_count[41:26],
  // zero pad.
  output logic [rcst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Fields, low bit up: status.
  output logic [rcst_pkg::STATUS_W-1:0]       m_axis_tuser
);

  rcst_pkg::ent_t ring [rcst_pkg::SLOTS];
  rcst_pkg::wr_t  wr;
  rcst_pkg::res_t res;
  rcst_pkg::res_t out_res;
  logic           shift;
  logic           res_load;
  logic           out_free;

  // The result register frees up in the same cycle its request is taken.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  rcst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .in_id    (s_axis_tdata[rcst_pkg::ID_IN_W-1:0]),
    .in_frame (s_axis_tdata[rcst_pkg::ID_IN_W +: rcst_pkg::FRAME_IN_W]),
    .head     (ring[0]),
    .out_free (out_free),
    .shift    (shift),
    .wr       (wr),
    .res      (res),
    .res_load (res_load)
  );

  // Each cell takes its upper neighbor's slot while scanning, so after a
  // full rotation every slot is back in the cell of its own index and the
  // write-back can address cells by slot number.
  for (genvar i = 0; i < rcst_pkg::SLOTS; i++) begin : g_cell
    localparam int NI = (i + 1) % rcst_pkg::SLOTS;
    rcst_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (rcst_pkg::SLOT_W'(i)),
      .shift    (shift),
      .nxt      (ring[NI]),
      .wr       (wr),
      .ent      (ring[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {{(rcst_pkg::OUT_TDATA_W - rcst_pkg::SLOT_OUT_W
                           - rcst_pkg::FRAME_OUT_W - rcst_pkg::COUNT_W){1'b0}},
                         out_res.count, out_res.frame, out_res.slot};
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

>>> hw/rtl/rcst_checker.sv
// ---------------------------------------------------------------------------
// rcst_checker
// Port-level checks of the segment table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "refcounted_segment_table_macros.svh"

module rcst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [rcst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [rcst_pkg::CMD_IN_W-1:0]    s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rcst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [rcst_pkg::STATUS_W-1:0]    m_axis_tuser
);

  // A stalled result keeps its valid and its contents.
  `RCST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Only one request is worked on at a time.
  `RCST_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Rejections carry no slot, frame or count.
  `RCST_ASSERT_SAME(a_reject_zero, m_axis_tvalid &&
                    (m_axis_tuser == rcst_pkg::ST_BAD_ID ||
                     m_axis_tuser == rcst_pkg::ST_FULL ||
                     m_axis_tuser == rcst_pkg::ST_NOT_FOUND),
                    m_axis_tdata == '0)

  // A newly created segment starts with exactly one reference.
  `RCST_ASSERT_SAME(a_create_one, m_axis_tvalid && m_axis_tuser == rcst_pkg::ST_CREATED,
                    m_axis_tdata[41:26] == 16'd1)

endmodule

bind refcounted_segment_table rcst_checker u_rcst_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Testbench for the reference-counted segment table
// Drives open and close requests over the input stream and checks every
// result on the output stream against a hand-written expectation or a
// testbench model of the slot table. A short directed table comes first,
// then random phases: noise, reuse of a few ids, fill to overflow, drain.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcst_pkg::*;

  localparam int RANDOM_REQUESTS = 1750;
  // Cycles with no handshake on either side before the run is declared hung.
  // The worst correct wait is a long sender gap plus one full scan plus the
  // longest receiver stall.
  localparam int HANG_LIMIT = 4000;
  // A nonzero id needs a full scan from acceptance to result, plus margin.
  localparam int SCAN_CYCLES = SLOTS + 6;

  // One request together with an optional hand-written expected result.
  typedef struct packed {
    logic [CMD_IN_W-1:0]   cmd;
    logic [ID_IN_W-1:0]    id;
    logic [FRAME_IN_W-1:0] frame;
    logic                  has_lit;
    res_t                  lit;
  } seg_req_t;

  typedef enum int {
    PH_NOISE,
    PH_REUSE,
    PH_FILL
  } phase_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_IN_W-1:0]    s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  refcounted_segment_table uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Testbench copy of the slot table.
  logic [ID_BITS-1:0]    seg_id    [SLOTS];
  logic [FRAME_BITS-1:0] seg_frame [SLOTS];
  logic [COUNT_W-1:0]    seg_count [SLOTS];

  res_t     pending_results[$];
  seg_req_t directed_reqs[$];
  seg_req_t cur_req = '0;
  logic [ID_IN_W-1:0] id_pool[$];

  int errors = 0;
  int burst_left = 0;
  int random_sent = 0;
  int fill_phases = 0;
  int status_seen[8];
  int rx_left = 0;
  int idle_cycles = 0;

  // Applies one request to the table copy and returns the result it causes.
  // The scan stops at the first matching slot and remembers the lowest empty
  // slot seen before that point, which is where a new segment goes.
  function automatic res_t apply_request(input seg_req_t r);
    res_t res;
    int   hit;
    int   empty;
    bit   found;
    bit   have_empty;
    res = '0;
    hit = 0;
    empty = 0;
    found = 1'b0;
    have_empty = 1'b0;
    if (r.id == '0) begin
      res.status = ST_BAD_ID;
      return res;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!have_empty && seg_id[i] == '0) begin
        have_empty = 1'b1;
        empty = i;
      end
      if (seg_id[i] == r.id) begin
        found = 1'b1;
        hit = i;
        break;
      end
    end
    if (r.cmd == CMD_OPEN) begin
      if (found) begin
        // The count saturates instead of wrapping back to zero.
        if (seg_count[hit] != COUNT_MAX) seg_count[hit] = seg_count[hit] + 1'b1;
        res.status = ST_OPENED;
        res.slot   = SLOT_OUT_W'(hit);
        res.frame  = seg_frame[hit];
        res.count  = seg_count[hit];
      end else if (have_empty) begin
        seg_id[empty]    = r.id;
        seg_frame[empty] = r.frame;
        seg_count[empty] = COUNT_ONE;
        res.status = ST_CREATED;
        res.slot   = SLOT_OUT_W'(empty);
        res.frame  = r.frame;
        res.count  = COUNT_ONE;
      end else begin
        res.status = ST_FULL;
      end
    end else if (!found) begin
      res.status = ST_NOT_FOUND;
    end else begin
      res.status = ST_CLOSED;
      res.slot   = SLOT_OUT_W'(hit);
      res.frame  = seg_frame[hit];
      if (seg_count[hit] > COUNT_ONE) begin
        seg_count[hit] = seg_count[hit] - 1'b1;
        res.count = seg_count[hit];
      end else begin
        // The last reference frees the slot; the old frame is still reported.
        seg_id[hit]    = '0;
        seg_frame[hit] = '0;
        seg_count[hit] = '0;
      end
    end
    return res;
  endfunction

  task automatic add_directed(input logic [CMD_IN_W-1:0] cmd, input logic [ID_IN_W-1:0] id,
                              input logic [FRAME_IN_W-1:0] frame, input logic has_lit,
                              input logic [STATUS_W-1:0] st, input int slot,
                              input logic [FRAME_OUT_W-1:0] fr_out,
                              input logic [COUNT_W-1:0] cnt);
    seg_req_t r;
    r.cmd        = cmd;
    r.id         = id;
    r.frame      = frame;
    r.has_lit    = has_lit;
    r.lit.status = st;
    r.lit.slot   = SLOT_OUT_W'(slot);
    r.lit.frame  = fr_out;
    r.lit.count  = cnt;
    directed_reqs.push_back(r);
  endtask

  // Presents one request and returns at the edge where it is accepted.
  // The sender works in bursts; between bursts tvalid may drop for a gap that
  // is sometimes long enough to land anywhere inside a table scan.
  task automatic send_request(input seg_req_t r);
    int gap;
    int pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) gap = 0;
      else if (pick < 8) gap = $urandom_range(1, 5);
      else gap = $urandom_range(20, 90);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - ID_IN_W - FRAME_IN_W){1'b0}}, r.frame, r.id};
    s_axis_tuser  <= r.cmd;
    cur_req       <= r;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic refill_pool(input int size, input bit allow_zero);
    int pick;
    id_pool.delete();
    for (int k = 0; k < size; k++) begin
      pick = $urandom_range(0, 29);
      if (allow_zero && pick == 0) id_pool.push_back('0);
      else if (pick == 1) id_pool.push_back('1);
      else if (pick == 2) id_pool.push_back(ID_IN_W'(1));
      else id_pool.push_back(ID_IN_W'($urandom_range(1, (1 << ID_IN_W) - 1)));
    end
  endtask

  // Sends up to n requests with ids drawn from the pool, a few stray ids
  // mixed in, and stops early once the random budget is used up.
  task automatic run_pool(input int n, input int open_pct);
    seg_req_t r;
    int       pick;
    for (int k = 0; k < n && random_sent < RANDOM_REQUESTS; k++) begin
      r = '0;
      if ($urandom_range(0, 99) < 4) begin
        r.id = ($urandom_range(0, 3) == 0) ? '0 : ID_IN_W'($urandom);
      end else begin
        r.id = id_pool[$urandom_range(0, id_pool.size() - 1)];
      end
      r.cmd = ($urandom_range(0, 99) < open_pct) ? CMD_OPEN : CMD_CLOSE;
      pick = $urandom_range(0, 9);
      if (pick == 0) r.frame = '0;
      else if (pick == 1) r.frame = '1;
      else r.frame = FRAME_IN_W'($urandom);
      send_request(r);
      random_sent++;
    end
  endtask

  // Every accepted request is run through the table copy right away, so the
  // expected results line up in the order the block will answer them.
  always @(posedge clk) begin : request_monitor
    res_t predicted;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predicted = apply_request(cur_req);
      if (cur_req.has_lit) pending_results.push_back(cur_req.lit);
      else pending_results.push_back(predicted);
    end
  end

  task automatic check_field(input string name, input longint unsigned exp_val,
                             input longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: tdata 0x%0h, tuser %0d",
               m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        status_seen[m_axis_tuser]++;
        check_field("status", want.status, m_axis_tuser);
        check_field("slot_index", want.slot, m_axis_tdata[5:0]);
        check_field("frame_out", want.frame, m_axis_tdata[25:6]);
        check_field("ref_count", want.count, m_axis_tdata[41:26]);
      end
    end
  end

  // The receiver alternates long ready stretches, choppy stalls and long
  // stalls that keep a finished result waiting in the output register.
  always @(posedge clk) begin : receiver_pattern
    int pick;
    if (rx_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        m_axis_tready <= 1'b1;
        rx_left <= $urandom_range(0, 150);
      end else if (pick < 8) begin
        m_axis_tready <= 1'b0;
        rx_left <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        rx_left <= $urandom_range(20, 100);
      end
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == HANG_LIMIT) begin
        $display("no handshake for %0d cycles, %0d results outstanding",
                 HANG_LIMIT, pending_results.size());
        $display("refcounted_segment_table test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    phase_t phase;
    int     total;
    for (int i = 0; i < SLOTS; i++) begin
      seg_id[i]    = '0;
      seg_frame[i] = '0;
      seg_count[i] = '0;
    end

    // Directed requests. Expected results are written out where they follow
    // directly from an empty table; the rest are left to the table copy.
    add_directed(CMD_CLOSE, 16'h0001, 20'h00000, 1'b1, ST_NOT_FOUND, 0, 20'h00000, 16'd0);
    add_directed(CMD_OPEN,  16'h0000, 20'hFFFFF, 1'b1, ST_BAD_ID,    0, 20'h00000, 16'd0);
    add_directed(CMD_CLOSE, 16'h0000, 20'hFFFFF, 1'b1, ST_BAD_ID,    0, 20'h00000, 16'd0);
    add_directed(CMD_OPEN,  16'hFFFF, 20'hFFFFF, 1'b1, ST_CREATED,   0, 20'hFFFFF, 16'd1);
    add_directed(CMD_OPEN,  16'h0001, 20'h00000, 1'b1, ST_CREATED,   1, 20'h00000, 16'd1);
    add_directed(CMD_OPEN,  16'hFFFF, 20'h00000, 1'b1, ST_OPENED,    0, 20'hFFFFF, 16'd2);
    add_directed(CMD_OPEN,  16'h8000, 20'h55555, 1'b1, ST_CREATED,   2, 20'h55555, 16'd1);
    add_directed(CMD_CLOSE, 16'hFFFF, 20'h12345, 1'b1, ST_CLOSED,    0, 20'hFFFFF, 16'd1);
    // The last reference frees slot zero but still reports its frame.
    add_directed(CMD_CLOSE, 16'hFFFF, 20'h00000, 1'b1, ST_CLOSED,    0, 20'hFFFFF, 16'd0);
    add_directed(CMD_CLOSE, 16'hFFFF, 20'h00000, 1'b1, ST_NOT_FOUND, 0, 20'h00000, 16'd0);
    // A new segment takes the lowest empty slot.
    add_directed(CMD_OPEN,  16'h7FFF, 20'hAAAAA, 1'b1, ST_CREATED,   0, 20'hAAAAA, 16'd1);
    add_directed(CMD_OPEN,  16'h0001, 20'h12345, 1'b1, ST_OPENED,    1, 20'h00000, 16'd2);
    add_directed(CMD_CLOSE, 16'h0001, 20'h00000, 1'b1, ST_CLOSED,    1, 20'h00000, 16'd1);
    add_directed(CMD_CLOSE, 16'h0001, 20'h00000, 1'b1, ST_CLOSED,    1, 20'h00000, 16'd0);
    add_directed(CMD_OPEN,  16'h0001, 20'h80000, 1'b1, ST_CREATED,   1, 20'h80000, 16'd1);
    add_directed(CMD_OPEN,  16'h8000, 20'h0F0F0, 1'b1, ST_OPENED,    2, 20'h55555, 16'd2);
    add_directed(CMD_OPEN,  16'h5A5A, 20'h0F0F0, 1'b0, ST_OPENED,    0, 20'h00000, 16'd0);
    add_directed(CMD_CLOSE, 16'h8000, 20'hFFFFF, 1'b0, ST_OPENED,    0, 20'h00000, 16'd0);
    add_directed(CMD_OPEN,  16'h0000, 20'h00000, 1'b1, ST_BAD_ID,    0, 20'h00000, 16'd0);
    add_directed(CMD_CLOSE, 16'h7FFF, 20'h00000, 1'b1, ST_CLOSED,    0, 20'hAAAAA, 16'd0);
    // An existing id further down wins over the empty slot above it.
    add_directed(CMD_OPEN,  16'h8000, 20'h00001, 1'b0, ST_OPENED,    0, 20'h00000, 16'd0);
    add_directed(CMD_OPEN,  16'h0002, 20'h3C3C3, 1'b0, ST_OPENED,    0, 20'h00000, 16'd0);
    add_directed(CMD_CLOSE, 16'hA5A5, 20'h00000, 1'b0, ST_OPENED,    0, 20'h00000, 16'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_reqs[k]) send_request(directed_reqs[k]);

    while (random_sent < RANDOM_REQUESTS) begin
      phase = phase_t'($urandom_range(0, 2));
      case (phase)
        PH_NOISE: begin
          refill_pool(40, 1'b1);
          run_pool($urandom_range(20, 40), 50);
        end
        PH_REUSE: begin
          refill_pool($urandom_range(1, 12), 1'b0);
          run_pool($urandom_range(40, 120), $urandom_range(50, 65));
        end
        default: begin
          // At least as many pool ids as slots, mostly opens, so the table runs
          // full; then mostly closes with the same ids drain it again.
          refill_pool($urandom_range(SLOTS, SLOTS + 16), 1'b0);
          run_pool($urandom_range(180, 260), 85);
          run_pool($urandom_range(220, 300), 10);
          fill_phases++;
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);

    total = 0;
    foreach (status_seen[s]) total += status_seen[s];
    $display("Checked %0d results after %0d directed and %0d random requests, %0d fill phases.",
             total, directed_reqs.size(), random_sent, fill_phases);
    $display("Seen: %0d reopened, %0d created, %0d full, %0d closed, %0d not found, %0d bad id.",
             status_seen[ST_OPENED], status_seen[ST_CREATED], status_seen[ST_FULL],
             status_seen[ST_CLOSED], status_seen[ST_NOT_FOUND], status_seen[ST_BAD_ID]);
    if (errors == 0) begin
      $display("refcounted_segment_table test passed");
    end else begin
      $display("refcounted_segment_table test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/rcst_pkg.sv
hw/rtl/rcst_cell.sv
hw/rtl/rcst_ctrl.sv
hw/rtl/refcounted_segment_table.sv
hw/rtl/rcst_checker.sv
tb/sv/tb_top.sv
